>>> rtl/ddst_pkg.sv
// ----------------------------------------------------------------------------
// ddst_pkg
// shared types and constants of the dimmer delay and staircase timer
// ----------------------------------------------------------------------------
package ddst_pkg;

  localparam int unsigned SecW   = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned TicksW = 26;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OptW = 3;

  localparam logic [TicksW-1:0] TicksPerS = TicksW'(1000);
  localparam logic [LevelW-1:0] FullLevel = 8'hFF;

  typedef enum logic [1:0] {
    ReqTick   = 2'd0,
    ReqSwitch = 2'd1,
    ReqStair  = 2'd2,
    ReqNone   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [SecW-1:0]   on_delay_s;
    logic [SecW-1:0]   off_delay_s;
    logic [SecW-1:0]   stair_time_s;
    logic [SecW-1:0]   prewarn_time_s;
    logic [LevelW-1:0] startup_level;
    logic [LevelW-1:0] warn_level;
    logic [SecW-1:0]   ramp_speeds;
    logic [OptW-1:0]   option_flags;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              obj_value;
    logic              switch_status;
    logic [LevelW-1:0] last_level;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] target_level;
    logic [LevelW-1:0] ramp_speed;
  } res_t;

  function automatic logic [TicksW-1:0] load_ticks(input logic [SecW-1:0] sec);
    load_ticks = TicksW'(sec) * TicksPerS + TicksW'(1);
  endfunction

endpackage

>>> rtl/ddst_cfg_regs.sv
// ----------------------------------------------------------------------------
// ddst_cfg_regs
// configuration register file written over the config channel
// ----------------------------------------------------------------------------
module ddst_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ddst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ddst_pkg::CfgDataW-1:0] cfg_data_i,
  output ddst_pkg::cfg_t           cfg_o
);
  import ddst_pkg::*;

  localparam logic [CfgIdxW-1:0] IdxOnDelay   = 3'd0;
  localparam logic [CfgIdxW-1:0] IdxOffDelay  = 3'd1;
  localparam logic [CfgIdxW-1:0] IdxStairTime = 3'd2;
  localparam logic [CfgIdxW-1:0] IdxPrewarn   = 3'd3;
  localparam logic [CfgIdxW-1:0] IdxStartup   = 3'd4;
  localparam logic [CfgIdxW-1:0] IdxWarnLevel = 3'd5;
  localparam logic [CfgIdxW-1:0] IdxRamp      = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxOptions   = 3'd7;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        IdxOnDelay:   cfg_d.on_delay_s     = cfg_data_i;
        IdxOffDelay:  cfg_d.off_delay_s    = cfg_data_i;
        IdxStairTime: cfg_d.stair_time_s   = cfg_data_i;
        IdxPrewarn:   cfg_d.prewarn_time_s = cfg_data_i;
        IdxStartup:   cfg_d.startup_level  = cfg_data_i[LevelW-1:0];
        IdxWarnLevel: cfg_d.warn_level     = cfg_data_i[LevelW-1:0];
        IdxRamp:      cfg_d.ramp_speeds    = cfg_data_i;
        IdxOptions:   cfg_d.option_flags   = cfg_data_i[OptW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_delay_s     <= '0;
      cfg_q.off_delay_s    <= '0;
      cfg_q.stair_time_s   <= SecW'(60);
      cfg_q.prewarn_time_s <= '0;
      cfg_q.startup_level  <= LevelW'(255);
      cfg_q.warn_level     <= LevelW'(128);
      cfg_q.ramp_speeds    <= '0;
      cfg_q.option_flags   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/ddst_ctrl.sv
// ----------------------------------------------------------------------------
// ddst_ctrl
// phase state, delay timer and dim command generation for one item
// ----------------------------------------------------------------------------
module ddst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  ddst_pkg::item_t item_i,
  input  ddst_pkg::cfg_t  cfg_i,
  output ddst_pkg::res_t  res_o
);
  import ddst_pkg::*;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhDlyOn  = 3'd1;
  localparam logic [2:0] PhDlyOff = 3'd2;
  localparam logic [2:0] PhStDly  = 3'd3;
  localparam logic [2:0] PhStOn   = 3'd4;
  localparam logic [2:0] PhStWarn = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic              armed_q, armed_d;
  logic              load;
  logic [SecW-1:0]   load_sec;
  logic [TicksW-1:0] ticks_dec;
  logic [LevelW-1:0] on_speed, off_speed;

  assign ticks_dec = ticks_q - TicksW'(1);
  assign on_speed  = cfg_i.ramp_speeds[LevelW-1:0];
  assign off_speed = cfg_i.ramp_speeds[SecW-1:LevelW];

  always_comb begin
    phase_d  = phase_q;
    armed_d  = armed_q;
    load     = 1'b0;
    load_sec = cfg_i.on_delay_s;
    res_o    = '0;
    unique case (req_type_e'(item_i.req_type))
      ReqTick: begin
        if (armed_q && ticks_dec == '0) begin
          armed_d = 1'b0;
          unique case (phase_q)
            PhDlyOn: begin
              res_o.valid        = 1'b1;
              res_o.target_level = cfg_i.option_flags[0] ? item_i.last_level
                                                         : cfg_i.startup_level;
              res_o.ramp_speed   = on_speed;
              phase_d            = PhIdle;
            end
            PhDlyOff, PhStWarn: begin
              res_o.valid      = 1'b1;
              res_o.ramp_speed = off_speed;
              phase_d          = PhIdle;
            end
            PhStDly: begin
              res_o.valid        = 1'b1;
              res_o.target_level = FullLevel;
              res_o.ramp_speed   = on_speed;
              phase_d            = PhStOn;
              load               = 1'b1;
              load_sec           = cfg_i.stair_time_s;
            end
            PhStOn: begin
              res_o.valid        = 1'b1;
              res_o.target_level = cfg_i.warn_level;
              res_o.ramp_speed   = on_speed;
              phase_d            = PhStWarn;
              load               = 1'b1;
              load_sec           = cfg_i.prewarn_time_s;
            end
            default: phase_d = phase_q;
          endcase
        end
      end
      ReqSwitch: begin
        if (item_i.obj_value != item_i.switch_status) begin
          if (item_i.obj_value && phase_q != PhDlyOn) begin
            load     = 1'b1;
            load_sec = cfg_i.on_delay_s;
            phase_d  = PhDlyOn;
          end else if (!item_i.obj_value && phase_q != PhDlyOff) begin
            load     = 1'b1;
            load_sec = cfg_i.off_delay_s;
            phase_d  = PhDlyOff;
          end
        end
      end
      ReqStair: begin
        if (!item_i.obj_value) begin
          if (cfg_i.option_flags[2]) begin
            res_o.valid      = 1'b1;
            res_o.ramp_speed = off_speed;
            phase_d          = PhIdle;
          end
        end else if (phase_q == PhIdle) begin
          load     = 1'b1;
          load_sec = cfg_i.on_delay_s;
          phase_d  = PhStDly;
        end else if ((phase_q == PhStOn || phase_q == PhStWarn) &&
                     cfg_i.option_flags[1]) begin
          load               = 1'b1;
          load_sec           = cfg_i.stair_time_s;
          phase_d            = PhStOn;
          res_o.valid        = 1'b1;
          res_o.target_level = FullLevel;
          res_o.ramp_speed   = on_speed;
        end
      end
      default: phase_d = phase_q;
    endcase
    if (load) begin
      armed_d = 1'b1;
      ticks_d = load_ticks(load_sec);
    end else if (req_type_e'(item_i.req_type) == ReqTick && armed_q) begin
      ticks_d = ticks_dec;
    end else begin
      ticks_d = ticks_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= '0;
      armed_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      armed_q <= armed_d;
    end
  end

  a_busy_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> armed_q)
    else $error("non-idle phase without running timer");

  a_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> ticks_q != '0)
    else $error("armed timer holds zero ticks");

  a_early_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.req_type == ReqStair && !item_i.obj_value &&
     cfg_i.option_flags[2]) |=> phase_q == PhIdle)
    else $error("off command did not return to idle");

endmodule

>>> rtl/dimmer_delay_staircase_timer.sv
// ----------------------------------------------------------------------------
// dimmer_delay_staircase_timer
// delay and staircase time functions of one dimmer channel
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with req_type_i, obj_value_i,
// switch_status_i and last_level_i. A transaction is a 1 ms tick, a switch
// telegram or a staircase telegram.
// Output channel: out_valid_o / out_stall_i with target_level_o and
// ramp_speed_o. Each input transaction gives zero or one dim command.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// ready is always high; write only while the block is idle.
// Path: an accepted transaction is held in the input register, and its dim
// command is registered in the output register when the output is not held.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the state and timer update between the input and output registers.
// Reset: phase idle, timer disarmed, registers at their defaults, both
// pipeline registers empty.
// Stall: a held output blocks the input register only; the input stalls
// once both registers are full and the receiver keeps stalling.
// ----------------------------------------------------------------------------
module dimmer_delay_staircase_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic                          obj_value_i,
  input  logic                          switch_status_i,
  input  logic [ddst_pkg::LevelW-1:0]   last_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ddst_pkg::LevelW-1:0]   target_level_o,
  output logic [ddst_pkg::LevelW-1:0]   ramp_speed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ddst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ddst_pkg::CfgDataW-1:0] cfg_data_i
);
  import ddst_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res;
  logic  in_valid_q;
  logic  out_valid_q;
  logic  [LevelW-1:0] level_q, speed_q;
  logic  out_busy, step, load_in;

  assign out_busy   = out_valid_q && out_stall_i;
  assign step       = in_valid_q && !out_busy;
  assign in_stall_o = in_valid_q && out_busy;
  assign load_in    = in_valid_i && !in_stall_o;

  ddst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ddst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!out_busy) begin
        out_valid_q <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      item_q.req_type      <= req_type_i;
      item_q.obj_value     <= obj_value_i;
      item_q.switch_status <= switch_status_i;
      item_q.last_level    <= last_level_i;
    end
    if (step && res.valid) begin
      level_q <= res.target_level;
      speed_q <= res.ramp_speed;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_level_o = level_q;
  assign ramp_speed_o   = speed_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline register");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.valid) |=> out_valid_o)
    else $error("dim command lost on its way to the output");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_busy) |=> in_valid_q)
    else $error("held transaction dropped while output stalled");

endmodule
